### rtl/core/etq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etq_pkg
// Types and constants shared by the event timer queue modules.
// ----------------------------------------------------------------------------
package etq_pkg;

  localparam int TIME_W     = 48;
  localparam int TMO_W      = 32;
  localparam int SLOT_W     = 6;
  localparam int LAZY_W     = 16;
  localparam int ACT_W      = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 56;

  localparam logic [LAZY_W-1:0] LAZY_RESET = 16'd300;
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_FIND = 2'd2
  } action_t;

  typedef struct packed {
    logic              armed;
    logic [TIME_W-1:0] deadline;
  } etq_entry_t;

  typedef struct packed {
    logic              add_skipped;
    logic              none_pending;
    logic [TIME_W-1:0] wait_ms;
  } etq_result_t;

endpackage

### rtl/core/etq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etq_mem
// Slot table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module etq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 49
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/etq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etq_core
// Sequencer: clearing pass, add read-modify-write, delete and the find scan.
// ----------------------------------------------------------------------------
module etq_core
  import etq_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [ACT_W-1:0]  req_action,
  input  logic [SLOT_W-1:0] req_slot,
  input  logic [TMO_W-1:0]  req_timeout,
  input  logic [TIME_W-1:0] req_now,
  input  logic [LAZY_W-1:0] lazy_delay,
  output logic              res_valid,
  input  logic              res_ready,
  output etq_result_t       res
);

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int SEXT_W = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;
  localparam int DW     = $bits(etq_entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_ADD_WR,
    S_FIND,
    S_FIND_END,
    S_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               dv_r, dv_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic [TIME_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  diff_r, diff_nxt;
  logic               armed_r, armed_nxt;
  logic               found_r, found_nxt;
  logic [TIME_W-1:0]  best_r, best_nxt;
  etq_result_t        res_r, res_nxt;

  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  etq_entry_t         mem_wr_entry;
  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [DW-1:0]      mem_rd_data;
  etq_entry_t         rd_entry;

  logic [TIME_W:0]    sum;
  logic [TIME_W-1:0]  key;
  logic [SEXT_W-1:0]  slot_ext;
  logic               in_range;
  logic [IDX_W-1:0]   slot_idx;
  logic               keep;

  etq_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IDX_W),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_entry),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign rd_entry = etq_entry_t'(mem_rd_data);

  assign sum      = {1'b0, req_now} + {{(TIME_W-TMO_W+1){1'b0}}, req_timeout};
  assign key      = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign slot_ext = SEXT_W'(req_slot);
  assign in_range = slot_ext < SEXT_W'(NUM_SLOTS);
  assign slot_idx = slot_ext[IDX_W-1:0];

  assign keep = armed_r && (diff_r[TIME_W-1:LAZY_W] == '0)
                && (diff_r[LAZY_W-1:0] < lazy_delay);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    dv_nxt       = 1'b0;
    addr_nxt     = addr_r;
    key_nxt      = key_r;
    now_nxt      = now_r;
    diff_nxt     = diff_r;
    armed_nxt    = armed_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    res_nxt      = res_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = slot_idx;
    mem_wr_entry = '0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = slot_idx;

    unique case (state_r)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r[IDX_W-1:0];
        if (cnt_r == CNT_W'(NUM_SLOTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          res_nxt   = '0;
          key_nxt   = key;
          now_nxt   = req_now;
          addr_nxt  = slot_idx;
          state_nxt = S_RESP;
          case (action_t'(req_action))
            ACT_ADD: begin
              if (in_range) begin
                mem_rd_en = 1'b1;
                state_nxt = S_ADD_CHK;
              end
            end
            ACT_DEL: begin
              mem_wr_en = in_range;
            end
            ACT_FIND: begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              cnt_nxt     = CNT_W'(1);
              dv_nxt      = 1'b1;
              found_nxt   = 1'b0;
              state_nxt   = S_FIND;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        armed_nxt = rd_entry.armed;
        diff_nxt  = (key_r >= rd_entry.deadline) ? key_r - rd_entry.deadline
                                                 : rd_entry.deadline - key_r;
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        if (keep) begin
          res_nxt.add_skipped = 1'b1;
        end else begin
          mem_wr_en             = 1'b1;
          mem_wr_addr           = addr_r;
          mem_wr_entry.armed    = 1'b1;
          mem_wr_entry.deadline = key_r;
        end
        state_nxt = S_RESP;
      end
      S_FIND: begin
        if (cnt_r != CNT_W'(NUM_SLOTS)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt_r[IDX_W-1:0];
          cnt_nxt     = cnt_r + 1'b1;
          dv_nxt      = 1'b1;
        end else begin
          state_nxt = S_FIND_END;
        end
        if (dv_r && rd_entry.armed && (!found_r || rd_entry.deadline < best_r)) begin
          best_nxt  = rd_entry.deadline;
          found_nxt = 1'b1;
        end
      end
      S_FIND_END: begin
        if (found_r) begin
          res_nxt.wait_ms = (best_r > now_r) ? best_r - now_r : '0;
        end else begin
          res_nxt.none_pending = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      dv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dv_r    <= dv_nxt;
    end
    addr_r  <= addr_nxt;
    key_r   <= key_nxt;
    now_r   <= now_nxt;
    diff_r  <= diff_nxt;
    armed_r <= armed_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    res_r   <= res_nxt;
  end

endmodule

### rtl/core/event_timer_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_timer_queue_unit
// One timer per event slot with lazy re-arm; find reports time to earliest
// deadline.
// ----------------------------------------------------------------------------
// One request is worked on at a time, and each gives one result. Slot state
// (deadline and armed flag) lives in a single-port-per-direction table with
// registered read data. A delete goes straight to the result, an add steps
// through read, compare, write back and result, and a find scans the table,
// reading one entry per cycle. After reset a clearing pass disarms every
// slot before the first request is taken; the lazy delay register can be
// written throughout. The result waits in an output register, so the next
// request is taken while it is still pending.
module event_timer_queue_unit
  import etq_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // event_slot[5:0], timeout_ms[37:6], now_ms[85:38], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // wait_ms[47:0], none_pending[48], add_skipped[49], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic [LAZY_W-1:0]     cfg_wr_data
);

  logic [LAZY_W-1:0] lazy_r;
  logic              res_valid;
  logic              res_ready;
  etq_result_t       res;
  logic              out_valid_r;
  etq_result_t       out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lazy_r <= LAZY_RESET;
    end else if (cfg_wr_en) begin
      lazy_r <= cfg_wr_data;
    end
  end

  etq_core #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_action  (in_tuser),
    .req_slot    (in_tdata[SLOT_W-1:0]),
    .req_timeout (in_tdata[SLOT_W+TMO_W-1:SLOT_W]),
    .req_now     (in_tdata[SLOT_W+TMO_W+TIME_W-1:SLOT_W+TMO_W]),
    .lazy_delay  (lazy_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-$bits(etq_result_t)){1'b0}}, out_r};

endmodule
